@@ src/assert_macros.svh @@
// Assertion helpers shared by the clipper RTL.
// Each use expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define WCSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define WCSC_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ src/wcsc_pkg.sv @@
//------------------------------------------------------------------------------
// wcsc_pkg: shared types and constants of the wall column span clipper
// Operation codes, span kinds, the job record that travels from the front
// end to the back end, and the back end state encoding.
//------------------------------------------------------------------------------
package wcsc_pkg;

    localparam int SCREEN_COLUMNS = 512;
    localparam int COL_AW = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [12:0] VIEW_HEIGHT_RESET = 13'd200;
    localparam logic [11:0] BOTTOM_RESET = 12'd199;
    localparam logic [12:0] VIEW_HEIGHT_MAX = 13'd4096;

    localparam logic [1:0] OP_FRAME_RESET = 2'd0;
    localparam logic [1:0] OP_WALL_LOAD = 2'd1;
    localparam logic [1:0] OP_COLUMN_STEP = 2'd2;

    localparam logic [2:0] KIND_CEILING = 3'd0;
    localparam logic [2:0] KIND_FLOOR = 3'd1;
    localparam logic [2:0] KIND_UPPER = 3'd2;
    localparam logic [2:0] KIND_MIDDLE = 3'd3;
    localparam logic [2:0] KIND_LOWER = 3'd4;

    // Bits of the wall span flags.
    localparam int FLAG_UPPER = 0;
    localparam int FLAG_MIDDLE = 1;
    localparam int FLAG_LOWER = 2;
    localparam int FLAG_CEILING = 3;
    localparam int FLAG_FLOOR = 4;

    localparam int EDGE_TOP = 0;
    localparam int EDGE_UPPER = 1;
    localparam int EDGE_LOWER = 2;
    localparam int EDGE_BOTTOM = 3;

    typedef enum logic
    {
        JOB_COLUMN,
        JOB_CLEAR
    } job_kind_t;

    // One unit of back end work: either a column to clip or a store sweep.
    typedef struct packed
    {
        job_kind_t        kind;
        logic [11:0]      column;
        logic [4:0]       flags;
        logic [11:0]      fill;
        logic [3:0][15:0] rows;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOOK,
        ST_EMIT,
        ST_CLEAR
    } back_state_t;

endpackage

@@ src/wall_column_span_clipper_unit.sv @@
//------------------------------------------------------------------------------
// wall_column_span_clipper_unit: per-column window clipper for wall spans
// Input items (frame reset, wall load, column step) enter on the in_ channel;
// clipped spans leave on the out_ channel, one transfer per span, with last
// set on the final span of a column. view_height is written over APB at
// byte address 0.
// A wall load is absorbed by the front end and causes no span.
// A column step is queued and then runs in the back end: clip store read, then
// clamp and window write-back, then enabled spans of an open window, one per
// cycle unless out_stall holds the output. The clip store read is registered.
// A frame reset rewrites the whole store, one column a cycle.
// After reset the store is swept the same way with in_stall high;
// configuration writes are taken during the sweep.
// A two-entry job queue lets the input side keep going while out_stall holds
// the back end; when the queue is full, in_stall rises. A stalled span holds
// its payload until it is taken.
//------------------------------------------------------------------------------
module wall_column_span_clipper_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [11:0]         x_first,
    input  logic [11:0]         x_last,
    input  logic signed [31:0]  top_edge,
    input  logic signed [31:0]  upper_edge,
    input  logic signed [31:0]  lower_edge,
    input  logic signed [31:0]  bottom_edge,
    input  logic signed [31:0]  top_step,
    input  logic signed [31:0]  upper_step,
    input  logic signed [31:0]  lower_step,
    input  logic signed [31:0]  bottom_step,
    input  logic [4:0]          span_flags,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [11:0]         column,
    output logic [2:0]          span_kind,
    output logic signed [13:0]  y_first,
    output logic signed [13:0]  y_last,
    output logic                last
);

    logic [12:0]    view_height_reg;
    logic           cfg_write;
    logic           reg_sel_height;

    logic           init_busy;
    logic           queue_full;
    logic           push;
    wcsc_pkg::job_t push_job;
    logic           pop;
    logic           head_valid;
    wcsc_pkg::job_t head_job;

    // Register index is the word address; only index zero exists.
    assign reg_sel_height = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = reg_sel_height ? {19'd0, view_height_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_height_reg <= wcsc_pkg::VIEW_HEIGHT_RESET;
        end
        else if (cfg_write && reg_sel_height)
        begin
            view_height_reg <= pwdata[12:0];
        end
    end

    wcsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .x_first     (x_first),
        .x_last      (x_last),
        .top_edge    (top_edge),
        .upper_edge  (upper_edge),
        .lower_edge  (lower_edge),
        .bottom_edge (bottom_edge),
        .top_step    (top_step),
        .upper_step  (upper_step),
        .lower_step  (lower_step),
        .bottom_step (bottom_step),
        .span_flags  (span_flags),
        .view_height (view_height_reg),
        .init_busy   (init_busy),
        .queue_full  (queue_full),
        .push        (push),
        .push_job    (push_job)
    );

    wcsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    wcsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .init_busy  (init_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .column     (column),
        .span_kind  (span_kind),
        .y_first    (y_first),
        .y_last     (y_last),
        .last       (last)
    );

endmodule

@@ src/wcsc_ram.sv @@
//------------------------------------------------------------------------------
// wcsc_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
//------------------------------------------------------------------------------
module wcsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/wcsc_queue.sv @@
//------------------------------------------------------------------------------
// wcsc_queue: short job queue between front and back end
// A small register FIFO of job records; the head is visible combinationally.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module wcsc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wcsc_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output wcsc_pkg::job_t head_job
);

    wcsc_pkg::job_t                entry_reg [wcsc_pkg::QUEUE_DEPTH];
    logic [wcsc_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [wcsc_pkg::QUEUE_AW-1:0] wr_ptr_next;
    logic [wcsc_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [wcsc_pkg::QUEUE_AW-1:0] rd_ptr_next;
    logic [wcsc_pkg::QUEUE_AW:0]   count_reg;
    logic [wcsc_pkg::QUEUE_AW:0]   count_next;

    localparam logic [wcsc_pkg::QUEUE_AW:0] COUNT_FULL =
        (wcsc_pkg::QUEUE_AW + 1)'(wcsc_pkg::QUEUE_DEPTH);
    localparam logic [wcsc_pkg::QUEUE_AW-1:0] PTR_LAST =
        wcsc_pkg::QUEUE_AW'(wcsc_pkg::QUEUE_DEPTH - 1);

    assign full = (count_reg == COUNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `WCSC_NEVER(a_queue_overflow, push && full, "job pushed into a full queue")
    `WCSC_NEVER(a_queue_underflow, pop && !head_valid, "job popped from an empty queue")

endmodule

@@ src/wcsc_front.sv @@
//------------------------------------------------------------------------------
// wcsc_front: item decode and wall walker
// Accepts input items, keeps the loaded wall (column range, edges, steps and
// flags), advances the edges per column step and queues back end jobs.
//------------------------------------------------------------------------------
module wcsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [11:0]         x_first,
    input  logic [11:0]         x_last,
    input  logic signed [31:0]  top_edge,
    input  logic signed [31:0]  upper_edge,
    input  logic signed [31:0]  lower_edge,
    input  logic signed [31:0]  bottom_edge,
    input  logic signed [31:0]  top_step,
    input  logic signed [31:0]  upper_step,
    input  logic signed [31:0]  lower_step,
    input  logic signed [31:0]  bottom_step,
    input  logic [4:0]          span_flags,
    input  logic [12:0]         view_height,
    input  logic                init_busy,
    input  logic                queue_full,
    output logic                push,
    output wcsc_pkg::job_t      push_job
);

    logic [11:0]      cur_col_reg;
    logic [11:0]      cur_col_next;
    logic [11:0]      end_col_reg;
    logic [11:0]      end_col_next;
    logic [3:0][31:0] edge_reg;
    logic [3:0][31:0] edge_next;
    logic [3:0][31:0] step_reg;
    logic [3:0][31:0] step_next;
    logic [4:0]       flags_reg;
    logic [4:0]       flags_next;
    logic             pending_reg;
    logic             pending_next;

    logic             accept;
    logic [3:0][31:0] rounded;
    logic [3:0][15:0] row_trunc;
    logic [3:0][32:0] sum;
    logic [3:0][31:0] edge_adv;
    logic [11:0]      fill_row;
    logic             in_store;

    assign in_stall = queue_full || init_busy;
    assign accept = in_valid && !in_stall;
    assign in_store = ({1'b0, cur_col_reg} < 13'(wcsc_pkg::SCREEN_COLUMNS));

    // New bottom clip row for a frame reset: the clamped height minus one.
    always_comb
    begin
        if (view_height == 13'd0)
        begin
            fill_row = 12'd0;
        end
        else if (view_height > wcsc_pkg::VIEW_HEIGHT_MAX)
        begin
            fill_row = 12'hFFF;
        end
        else
        begin
            fill_row = 12'(view_height - 13'd1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // Adding 0xFFFF to a negative value before the arithmetic shift
            // turns the floor into a truncation toward zero.
            rounded[i] = edge_reg[i] + {16'd0, {16{edge_reg[i][31]}}};
            row_trunc[i] = rounded[i][31:16];
            sum[i] = {edge_reg[i][31], edge_reg[i]} + {step_reg[i][31], step_reg[i]};
            if (sum[i][32] != sum[i][31])
            begin
                edge_adv[i] = sum[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                edge_adv[i] = sum[i][31:0];
            end
        end
    end

    always_comb
    begin
        cur_col_next = cur_col_reg;
        end_col_next = end_col_reg;
        edge_next = edge_reg;
        step_next = step_reg;
        flags_next = flags_reg;
        pending_next = pending_reg;
        push = 1'b0;
        push_job.kind = wcsc_pkg::JOB_COLUMN;
        push_job.column = cur_col_reg;
        push_job.flags = flags_reg;
        push_job.fill = fill_row;
        push_job.rows = row_trunc;
        if (accept)
        begin
            case (operation)
                wcsc_pkg::OP_FRAME_RESET:
                begin
                    push = 1'b1;
                    push_job.kind = wcsc_pkg::JOB_CLEAR;
                end
                wcsc_pkg::OP_WALL_LOAD:
                begin
                    cur_col_next = x_first;
                    end_col_next = x_last;
                    edge_next[wcsc_pkg::EDGE_TOP] = top_edge;
                    edge_next[wcsc_pkg::EDGE_UPPER] = upper_edge;
                    edge_next[wcsc_pkg::EDGE_LOWER] = lower_edge;
                    edge_next[wcsc_pkg::EDGE_BOTTOM] = bottom_edge;
                    step_next[wcsc_pkg::EDGE_TOP] = top_step;
                    step_next[wcsc_pkg::EDGE_UPPER] = upper_step;
                    step_next[wcsc_pkg::EDGE_LOWER] = lower_step;
                    step_next[wcsc_pkg::EDGE_BOTTOM] = bottom_step;
                    flags_next = span_flags;
                    pending_next = (x_first <= x_last);
                end
                wcsc_pkg::OP_COLUMN_STEP:
                begin
                    if (pending_reg)
                    begin
                        // Columns past the store are closed: no job, but the
                        // edges still advance.
                        push = in_store;
                        edge_next = edge_adv;
                        if (cur_col_reg >= end_col_reg)
                        begin
                            pending_next = 1'b0;
                        end
                        else
                        begin
                            cur_col_next = cur_col_reg + 12'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            end_col_reg <= '0;
            edge_reg <= '0;
            step_reg <= '0;
            flags_reg <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg <= cur_col_next;
            end_col_reg <= end_col_next;
            edge_reg <= edge_next;
            step_reg <= step_next;
            flags_reg <= flags_next;
            pending_reg <= pending_next;
        end
    end

endmodule

@@ src/wcsc_back.sv @@
//------------------------------------------------------------------------------
// wcsc_back: clip store and span emitter
// Runs queued jobs one at a time: reads a column's window, clamps the edges,
// narrows the window and sends the enabled spans, or sweeps the clip store.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module wcsc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  wcsc_pkg::job_t      head_job,
    output logic                pop,
    output logic                init_busy,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [11:0]         column,
    output logic [2:0]          span_kind,
    output logic signed [13:0]  y_first,
    output logic signed [13:0]  y_last,
    output logic                last
);

    localparam logic [wcsc_pkg::COL_AW-1:0] ADDR_LAST =
        wcsc_pkg::COL_AW'(wcsc_pkg::SCREEN_COLUMNS - 1);

    wcsc_pkg::back_state_t         state_reg;
    wcsc_pkg::back_state_t         state_next;
    wcsc_pkg::job_t                job_reg;
    logic [11:0]                   ct_reg;
    logic [11:0]                   cb_reg;
    logic [11:0]                   t_reg;
    logic [11:0]                   h_reg;
    logic [11:0]                   l_reg;
    logic [11:0]                   b_reg;
    logic [4:0]                    pend_reg;
    logic [wcsc_pkg::COL_AW-1:0]   clr_addr_reg;
    logic [11:0]                   fill_reg;
    logic                          init_reg;

    logic                          out_valid_reg;
    logic [11:0]                   column_reg;
    logic [2:0]                    kind_reg;
    logic signed [13:0]            y_first_reg;
    logic signed [13:0]            y_last_reg;
    logic                          last_reg;

    logic                          ram_we;
    logic [wcsc_pkg::COL_AW-1:0]   ram_waddr;
    logic [23:0]                   ram_wdata;
    logic [wcsc_pkg::COL_AW-1:0]   ram_raddr;
    logic [23:0]                   ram_rdata;

    logic [11:0]                   rd_top;
    logic [11:0]                   rd_bottom;
    logic                          win_open;
    logic [11:0]                   t_cl;
    logic [11:0]                   h_cl;
    logic [11:0]                   l_cl;
    logic [11:0]                   b_cl;
    logic [4:0]                    look_mask;

    logic                          out_free;
    logic                          out_load;
    logic [2:0]                    sel_kind;
    logic [4:0]                    sel_hot;
    logic [4:0]                    pend_rest;
    logic signed [13:0]            span_y0;
    logic signed [13:0]            span_y1;
    logic                          clear_done;

    function automatic logic [11:0] clamp_row(
        input logic [15:0] row,
        input logic [11:0] lo,
        input logic [11:0] hi
    );
        logic signed [15:0] r;
        r = $signed(row);
        if (r < $signed({4'd0, lo}))
        begin
            return lo;
        end
        else if (r > $signed({4'd0, hi}))
        begin
            return hi;
        end
        return r[11:0];
    endfunction

    wcsc_ram #(
        .WIDTH (24),
        .DEPTH (wcsc_pkg::SCREEN_COLUMNS)
    ) u_clip_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Window read back in ST_LOOK and the clamped edge rows.
    assign rd_top = ram_rdata[23:12];
    assign rd_bottom = ram_rdata[11:0];
    assign win_open = (rd_top < rd_bottom);
    assign t_cl = clamp_row(job_reg.rows[wcsc_pkg::EDGE_TOP], rd_top, rd_bottom);
    assign h_cl = clamp_row(job_reg.rows[wcsc_pkg::EDGE_UPPER], rd_top, rd_bottom);
    assign l_cl = clamp_row(job_reg.rows[wcsc_pkg::EDGE_LOWER], rd_top, rd_bottom);
    assign b_cl = clamp_row(job_reg.rows[wcsc_pkg::EDGE_BOTTOM], rd_top, rd_bottom);

    // Pending spans are held in emission order, indexed by span kind.
    assign look_mask = win_open ?
        {job_reg.flags[wcsc_pkg::FLAG_LOWER], job_reg.flags[wcsc_pkg::FLAG_MIDDLE],
         job_reg.flags[wcsc_pkg::FLAG_UPPER], job_reg.flags[wcsc_pkg::FLAG_FLOOR],
         job_reg.flags[wcsc_pkg::FLAG_CEILING]} : 5'd0;

    assign out_free = !out_valid_reg || !out_stall;
    assign clear_done = (clr_addr_reg == ADDR_LAST);

    always_comb
    begin
        sel_kind = wcsc_pkg::KIND_LOWER;
        for (int i = 4; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel_kind = 3'(i);
            end
        end
        sel_hot = 5'd1 << sel_kind;
        pend_rest = pend_reg & ~sel_hot;
    end

    always_comb
    begin
        case (sel_kind)
            wcsc_pkg::KIND_CEILING:
            begin
                span_y0 = $signed({2'b00, ct_reg});
                span_y1 = $signed({2'b00, t_reg}) - 14'sd1;
            end
            wcsc_pkg::KIND_FLOOR:
            begin
                span_y0 = $signed({2'b00, b_reg}) + 14'sd1;
                span_y1 = $signed({2'b00, cb_reg});
            end
            wcsc_pkg::KIND_UPPER:
            begin
                span_y0 = $signed({2'b00, t_reg});
                span_y1 = $signed({2'b00, h_reg});
            end
            wcsc_pkg::KIND_MIDDLE:
            begin
                span_y0 = $signed({2'b00, h_reg});
                span_y1 = $signed({2'b00, l_reg});
            end
            default:
            begin
                span_y0 = $signed({2'b00, l_reg});
                span_y1 = $signed({2'b00, b_reg});
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wcsc_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = (head_job.kind == wcsc_pkg::JOB_CLEAR) ?
                        wcsc_pkg::ST_CLEAR : wcsc_pkg::ST_LOOK;
                end
            end
            wcsc_pkg::ST_LOOK:
            begin
                state_next = (look_mask != 5'd0) ? wcsc_pkg::ST_EMIT : wcsc_pkg::ST_IDLE;
            end
            wcsc_pkg::ST_EMIT:
            begin
                if (out_free && (pend_rest == 5'd0))
                begin
                    state_next = wcsc_pkg::ST_IDLE;
                end
            end
            wcsc_pkg::ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = wcsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wcsc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = job_reg.column[wcsc_pkg::COL_AW-1:0];
        ram_wdata = {h_cl, l_cl};
        ram_raddr = head_job.column[wcsc_pkg::COL_AW-1:0];
        out_load = 1'b0;
        case (state_reg)
            wcsc_pkg::ST_IDLE:
            begin
                pop = head_valid;
            end
            wcsc_pkg::ST_LOOK:
            begin
                ram_we = win_open;
            end
            wcsc_pkg::ST_EMIT:
            begin
                out_load = out_free;
            end
            wcsc_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = {12'd0, fill_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcsc_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            fill_reg <= wcsc_pkg::BOTTOM_RESET;
            init_reg <= 1'b1;
            pend_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && (head_job.kind == wcsc_pkg::JOB_CLEAR))
            begin
                fill_reg <= head_job.fill;
                clr_addr_reg <= '0;
            end
            else if (state_reg == wcsc_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clear_done ? '0 : clr_addr_reg + 1'b1;
                if (clear_done)
                begin
                    init_reg <= 1'b0;
                end
            end
            if (state_reg == wcsc_pkg::ST_LOOK)
            begin
                pend_reg <= look_mask;
            end
            else if (out_load)
            begin
                pend_reg <= pend_rest;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
        if (state_reg == wcsc_pkg::ST_LOOK)
        begin
            ct_reg <= rd_top;
            cb_reg <= rd_bottom;
            t_reg <= t_cl;
            h_reg <= h_cl;
            l_reg <= l_cl;
            b_reg <= b_cl;
        end
        if (out_load)
        begin
            column_reg <= job_reg.column;
            kind_reg <= sel_kind;
            y_first_reg <= span_y0;
            y_last_reg <= span_y1;
            last_reg <= (pend_rest == 5'd0);
        end
    end

    assign init_busy = init_reg;
    assign out_valid = out_valid_reg;
    assign column = column_reg;
    assign span_kind = kind_reg;
    assign y_first = y_first_reg;
    assign y_last = y_last_reg;
    assign last = last_reg;

    `WCSC_ASSERT(a_emit_has_work, (state_reg == wcsc_pkg::ST_EMIT) |-> (pend_reg != 5'd0), "emit state with no span pending")
    `WCSC_ASSERT(a_look_one_cycle, (state_reg == wcsc_pkg::ST_LOOK) |=> (state_reg == wcsc_pkg::ST_EMIT || state_reg == wcsc_pkg::ST_IDLE), "window lookup did not finish in one cycle")
    `WCSC_ASSERT(a_last_ends_column, (out_load && (pend_rest == 5'd0)) |=> (last_reg && state_reg == wcsc_pkg::ST_IDLE), "final span of a column not marked or column not closed")
    `WCSC_NEVER(a_init_no_pop, init_reg && pop, "job taken during the clearing pass after reset")

endmodule

@@ tb/tb.sv @@
//------------------------------------------------------------------------------
// tb: self-checking testbench for wall_column_span_clipper_unit
// A driver feeds frame resets, wall loads, column steps and unused operations from
// a queue of pending items, and a predictor mirrors the per-column clip windows to
// work out the spans each accepted column step should produce. A monitor checks
// every span transfer in order. The run steps view_height through its
// extremes between phases and applies random idling and one long output hold.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_VIEW_HEIGHT = 3'd0;
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;

    typedef struct packed
    {
        logic [1:0]       operation;
        logic [11:0]      x_first;
        logic [11:0]      x_last;
        logic [3:0][31:0] edges;
        logic [3:0][31:0] steps;
        logic [4:0]       span_flags;
    } clip_item_t;

    typedef struct packed
    {
        logic [11:0] column;
        logic [2:0]  kind;
        logic [13:0] y_first;
        logic [13:0] y_last;
        logic        last;
    } span_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic       in_valid = 1'b0;
    logic       in_stall;
    clip_item_t offer = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [11:0]        column;
    logic [2:0]         span_kind;
    logic signed [13:0] y_first;
    logic signed [13:0] y_last;
    logic               last;

    clip_item_t pending_items[$];
    span_t      spans_due[$];
    bit         calm = 1'b0;
    int         err_count = 0;
    int         cycle_count = 0;

    // Predictor state.
    logic [12:0] vh_now = wcsc_pkg::VIEW_HEIGHT_RESET;
    logic [11:0] top_clip[wcsc_pkg::SCREEN_COLUMNS];
    logic [11:0] bottom_clip[wcsc_pkg::SCREEN_COLUMNS];
    logic [11:0] wall_col = '0;
    logic [11:0] wall_end = '0;
    longint      edge_pos[4];
    longint      edge_inc[4];
    logic [4:0]  wall_flags = '0;
    bit          wall_live = 1'b0;

    wall_column_span_clipper_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (offer.operation),
        .x_first     (offer.x_first),
        .x_last      (offer.x_last),
        .top_edge    (offer.edges[wcsc_pkg::EDGE_TOP]),
        .upper_edge  (offer.edges[wcsc_pkg::EDGE_UPPER]),
        .lower_edge  (offer.edges[wcsc_pkg::EDGE_LOWER]),
        .bottom_edge (offer.edges[wcsc_pkg::EDGE_BOTTOM]),
        .top_step    (offer.steps[wcsc_pkg::EDGE_TOP]),
        .upper_step  (offer.steps[wcsc_pkg::EDGE_UPPER]),
        .lower_step  (offer.steps[wcsc_pkg::EDGE_LOWER]),
        .bottom_step (offer.steps[wcsc_pkg::EDGE_BOTTOM]),
        .span_flags  (offer.span_flags),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .column      (column),
        .span_kind   (span_kind),
        .y_first     (y_first),
        .y_last      (y_last),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int eff_height();
        if (vh_now == 0)
            return 1;
        if (vh_now > wcsc_pkg::VIEW_HEIGHT_MAX)
            return 4096;
        return int'(vh_now);
    endfunction

    function automatic void open_store();
        logic [11:0] bot;
        bot = 12'(eff_height() - 1);
        for (int i = 0; i < wcsc_pkg::SCREEN_COLUMNS; i++)
        begin
            top_clip[i] = '0;
            bottom_clip[i] = bot;
        end
    endfunction

    // Edge rows are 16.16; the row is the integer part truncated toward zero.
    function automatic longint pin_row(longint pos, longint lo, longint hi);
        longint r;
        r = pos / 64'sd65536;
        if (r < lo)
            return lo;
        if (r > hi)
            return hi;
        return r;
    endfunction

    function automatic longint sat32(longint v);
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        return v;
    endfunction

    function automatic span_t make_span(logic [11:0] col, logic [2:0] kind, longint y0,
                                        longint y1);
        span_t s;
        s.column = col;
        s.kind = kind;
        s.y_first = 14'(y0);
        s.y_last = 14'(y1);
        s.last = 1'b0;
        return s;
    endfunction

    task automatic advance_clipper(input clip_item_t it);
        span_t  found[$];
        longint ct, cb, t, h, l, b;
        if (it.operation == wcsc_pkg::OP_FRAME_RESET)
        begin
            open_store();
        end
        else if (it.operation == wcsc_pkg::OP_WALL_LOAD)
        begin
            wall_col = it.x_first;
            wall_end = it.x_last;
            for (int e = 0; e < 4; e++)
            begin
                edge_pos[e] = $signed(it.edges[e]);
                edge_inc[e] = $signed(it.steps[e]);
            end
            wall_flags = it.span_flags;
            wall_live = (it.x_first <= it.x_last);
        end
        else if (it.operation == wcsc_pkg::OP_COLUMN_STEP && wall_live)
        begin
            // Columns past the store count as closed.
            if (wall_col < wcsc_pkg::SCREEN_COLUMNS)
            begin
                ct = top_clip[wall_col];
                cb = bottom_clip[wall_col];
                if (ct < cb)
                begin
                    t = pin_row(edge_pos[wcsc_pkg::EDGE_TOP], ct, cb);
                    h = pin_row(edge_pos[wcsc_pkg::EDGE_UPPER], ct, cb);
                    l = pin_row(edge_pos[wcsc_pkg::EDGE_LOWER], ct, cb);
                    b = pin_row(edge_pos[wcsc_pkg::EDGE_BOTTOM], ct, cb);
                    if (wall_flags[wcsc_pkg::FLAG_CEILING])
                        found.push_back(make_span(wall_col, wcsc_pkg::KIND_CEILING,
                                                  ct, t - 1));
                    if (wall_flags[wcsc_pkg::FLAG_FLOOR])
                        found.push_back(make_span(wall_col, wcsc_pkg::KIND_FLOOR,
                                                  b + 1, cb));
                    if (wall_flags[wcsc_pkg::FLAG_UPPER])
                        found.push_back(make_span(wall_col, wcsc_pkg::KIND_UPPER, t, h));
                    if (wall_flags[wcsc_pkg::FLAG_MIDDLE])
                        found.push_back(make_span(wall_col, wcsc_pkg::KIND_MIDDLE, h, l));
                    if (wall_flags[wcsc_pkg::FLAG_LOWER])
                        found.push_back(make_span(wall_col, wcsc_pkg::KIND_LOWER, l, b));
                    if (found.size() > 0)
                        found[found.size() - 1].last = 1'b1;
                    foreach (found[i])
                        spans_due.push_back(found[i]);
                    top_clip[wall_col] = 12'(h);
                    bottom_clip[wall_col] = 12'(l);
                end
            end
            for (int e = 0; e < 4; e++)
                edge_pos[e] = sat32(edge_pos[e] + edge_inc[e]);
            if (wall_col >= wall_end)
                wall_live = 1'b0;
            else
                wall_col = wall_col + 12'd1;
        end
    endtask

    // Driver: presents pending items and runs each transfer through the predictor.
    always @(posedge clk)
    begin : drive_proc
        logic go;
        int   gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            go = in_valid;
            if (in_valid && !in_stall)
            begin
                advance_clipper(offer);
                go = 1'b0;
                if (!calm && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 11);
            end
            if (!go)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_items.size() > 0)
                begin
                    offer <= pending_items.pop_front();
                    go = 1'b1;
                end
            end
            in_valid <= go;
        end
    end

    // Receiver: random stall bursts plus one long hold so the job queue backs up.
    always @(posedge clk)
    begin : stall_proc
        logic nxt;
        int   taken;
        int   hold_left;
        int   burst_left;
        bit   hold_done;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            taken = 0;
            hold_left = 0;
            burst_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b1;
            end
            else if (!hold_done && taken >= 20)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                nxt = 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                nxt = 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(1, 11) - 1;
                nxt = 1'b1;
            end
            else
            begin
                nxt = 1'b0;
            end
            out_stall <= nxt;
        end
    end

    // Monitor: each span transfer must match the oldest predicted span.
    always @(posedge clk)
    begin : check_proc
        span_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (spans_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected span: col %0d kind %0d rows %0d..%0d last %0b",
                             $realtime, column, span_kind, y_first, y_last, last);
            end
            else
            begin
                want = spans_due.pop_front();
                if (column !== want.column || span_kind !== want.kind
                    || y_first !== want.y_first || y_last !== want.y_last
                    || last !== want.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("%0t: span mismatch", $realtime);
                        $display("  expected col %0d kind %0d rows %0d..%0d last %0b",
                                 want.column, want.kind, $signed(want.y_first),
                                 $signed(want.y_last), want.last);
                        $display("  actual   col %0d kind %0d rows %0d..%0d last %0b",
                                 column, span_kind, y_first, y_last, last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic clip_item_t random_item(logic [1:0] op);
        clip_item_t it;
        it.operation = op;
        it.x_first = 12'($urandom());
        it.x_last = 12'($urandom());
        for (int e = 0; e < 4; e++)
        begin
            it.edges[e] = $urandom();
            it.steps[e] = $urandom();
        end
        it.span_flags = 5'($urandom());
        return it;
    endfunction

    function automatic clip_item_t make_load(logic [11:0] first, logic [11:0] final_col,
                                             logic [31:0] t, logic [31:0] u, logic [31:0] l,
                                             logic [31:0] b, logic [31:0] ts, logic [31:0] us,
                                             logic [31:0] ls, logic [31:0] bs,
                                             logic [4:0] flags);
        clip_item_t it;
        it.operation = wcsc_pkg::OP_WALL_LOAD;
        it.x_first = first;
        it.x_last = final_col;
        it.edges[wcsc_pkg::EDGE_TOP] = t;
        it.edges[wcsc_pkg::EDGE_UPPER] = u;
        it.edges[wcsc_pkg::EDGE_LOWER] = l;
        it.edges[wcsc_pkg::EDGE_BOTTOM] = b;
        it.steps[wcsc_pkg::EDGE_TOP] = ts;
        it.steps[wcsc_pkg::EDGE_UPPER] = us;
        it.steps[wcsc_pkg::EDGE_LOWER] = ls;
        it.steps[wcsc_pkg::EDGE_BOTTOM] = bs;
        it.span_flags = flags;
        return it;
    endfunction

    // Row near the open window, with a random fraction.
    function automatic logic [31:0] row_value();
        int r;
        r = int'($urandom_range(0, eff_height() + 40)) - 20;
        return 32'(r * 65536 + int'($urandom_range(0, 65535)));
    endfunction

    function automatic logic [31:0] slope_value();
        return 32'((int'($urandom_range(0, 16)) - 8) * 65536
                   + int'($urandom_range(0, 65535)) - 32768);
    endfunction

    task automatic queue_directed();
        repeat (2)
            pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
        pending_items.push_back(random_item(OP_UNUSED));
        // Plain wall over four columns with fractional edges and slopes.
        pending_items.push_back(make_load(12'd0, 12'd3, 32'h0014_8000, 32'h003C_0000,
                                          32'h008C_0000, 32'h00B4_0000, 32'h0001_4000,
                                          32'hFFFF_8000, 32'h0000_C000, 32'hFFFE_0000,
                                          5'b11111));
        repeat (4)
            pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
        // Reversed range loads nothing; the step after it is ignored.
        pending_items.push_back(make_load(12'd20, 12'd19, 32'h0010_0000, 32'h0020_0000,
                                          32'h0030_0000, 32'h0040_0000, '0, '0, '0, '0,
                                          5'b11111));
        pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
        // Edges at the 32-bit limits saturate; the last two columns lie past the store.
        pending_items.push_back(make_load(12'd508, 12'd513, 32'h7FFF_0000, 32'hFFFE_8000,
                                          32'h00C8_8000, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000,
                                          5'b11111));
        repeat (6)
            pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
        // No spans enabled, but the window of column 40 still closes to one row.
        pending_items.push_back(make_load(12'd40, 12'd40, '0, 32'h0064_0000, 32'h0064_0000,
                                          32'h00C7_0000, '0, '0, '0, '0, 5'b00000));
        pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
        // Column 40 is now closed; the frame reset leaves the wall pending for 41.
        pending_items.push_back(make_load(12'd40, 12'd41, 32'h0010_0000, 32'h0020_0000,
                                          32'h00A0_0000, 32'h00B0_0000, 32'h0000_8000,
                                          32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                                          5'b11010));
        pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
        pending_items.push_back(random_item(wcsc_pkg::OP_FRAME_RESET));
        pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
        pending_items.push_back(make_load(12'd4095, 12'd4095, 32'h0001_0000, 32'h0002_0000,
                                          32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0,
                                          5'b11111));
        pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
    endtask

    task automatic queue_random_phase(input int unsigned quota);
        clip_item_t  it;
        int unsigned filled;
        int unsigned runs;
        int unsigned pick;
        int unsigned first;
        pending_items.push_back(random_item(wcsc_pkg::OP_FRAME_RESET));
        filled = 1;
        while (filled < quota)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                pending_items.push_back(random_item(OP_UNUSED));
                filled++;
            end
            else if (pick == 1)
            begin
                pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
                filled++;
            end
            else if (pick == 2)
            begin
                pending_items.push_back(random_item(wcsc_pkg::OP_FRAME_RESET));
                filled++;
            end
            else
            begin
                it = random_item(wcsc_pkg::OP_WALL_LOAD);
                if (pick == 3)
                begin
                    // Raw column range and edges: often reversed or very long.
                    runs = $urandom_range(0, 3);
                end
                else
                begin
                    first = (pick == 4) ? $urandom_range(505, 511)
                                        : $urandom_range(0, wcsc_pkg::SCREEN_COLUMNS - 1);
                    runs = $urandom_range(1, 6);
                    it.x_first = 12'(first);
                    it.x_last = 12'(first + runs - 1);
                    if ($urandom_range(0, 4) == 0)
                        runs++;
                    for (int e = 0; e < 4; e++)
                    begin
                        if ($urandom_range(0, 7) != 0)
                            it.edges[e] = row_value();
                        if ($urandom_range(0, 7) != 0)
                            it.steps[e] = slope_value();
                    end
                end
                pending_items.push_back(it);
                repeat (runs)
                    pending_items.push_back(random_item(wcsc_pkg::OP_COLUMN_STEP));
                filled += 1 + runs;
            end
        end
    endtask

    task automatic await_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || spans_due.size() != 0);
        // A frame reset may still be sweeping the store.
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_view_height(input logic [12:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_VIEW_HEIGHT;
        pwdata <= {19'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        vh_now = value;
    endtask

    initial
    begin
        logic [12:0] heights[7];
        int unsigned quotas[7];
        for (int e = 0; e < 4; e++)
        begin
            edge_pos[e] = 0;
            edge_inc[e] = 0;
        end
        open_store();
        heights = '{13'd0, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd0, 13'd77};
        heights[0] = 13'($urandom_range(2, 4095));
        heights[5] = 13'($urandom_range(2, 4095));
        quotas = '{18, 6, 16, 6, 14, 13, 18};

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        await_idle();
        for (int p = 0; p < 7; p++)
        begin
            write_view_height(heights[p]);
            if (p == 6)
                calm = 1'b1;
            queue_random_phase(quotas[p]);
            await_idle();
        end

        if (err_count == 0 && spans_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/wcsc_pkg.sv
src/wcsc_ram.sv
src/wcsc_queue.sv
src/wcsc_front.sv
src/wcsc_back.sv
src/wall_column_span_clipper_unit.sv
tb/tb.sv
